// ===== hw/rtl/rbpa_pkg.sv =====
package rbpa_pkg;

  // Request codes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_RELEASE = 2'd1;
  localparam opcode_t OP_ADD_REF = 2'd2;
  localparam opcode_t OP_NOP     = 2'd3;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NO_FREE  = 3'd1;
  localparam status_t ST_NOT_HELD = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, read count memory, latch first free block
    logic commit;   // write back state and load the result register
  } rbpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register full and not taken this cycle
  } rbpa_stat_t;

endpackage

// ===== hw/rtl/rbpa_ctrl.sv =====
module rbpa_ctrl
  import rbpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rbpa_stat_t stat,
  output rbpa_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Take a request only when idle
  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == ST_EXEC) && !stat.out_stall;

  // Advance between capture and commit
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/rbpa_datapath.sv =====
module rbpa_datapath
  import rbpa_pkg::*;
#(
  parameter int NUM_BLOCKS = 64,
  parameter int COUNT_BITS = 8,
  parameter int IDX_W      = $clog2(NUM_BLOCKS),
  parameter int USE_W      = $clog2(NUM_BLOCKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rbpa_cmd_t             cmd,
  output rbpa_stat_t            stat,
  input  opcode_t               opcode,
  input  logic [IDX_W-1:0]      block_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output status_t               status,
  output logic [IDX_W-1:0]      granted_index,
  output logic [COUNT_BITS-1:0] ref_count_after,
  output logic [USE_W-1:0]      blocks_in_use,
  output logic [USE_W-1:0]      peak_in_use
);

  localparam logic [IDX_W:0]      NB_LIMIT  = (IDX_W + 1)'(NUM_BLOCKS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [USE_W-1:0]    USE_ONE   = USE_W'(1);

  // Count storage and held bitmap (held clear means count is zero)
  logic [COUNT_BITS-1:0] counts [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] held;
  logic [USE_W-1:0]      in_use_total;
  logic [USE_W-1:0]      peak_total;

  // Captured request
  opcode_t               op_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  range_q;
  logic                  held_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic [IDX_W-1:0]      free_q;
  logic                  any_free_q;

  logic                  in_range;
  logic [IDX_W-1:0]      free_idx;
  logic                  any_free;

  logic [COUNT_BITS-1:0] cur_cnt;
  status_t               res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  set_held;
  logic                  clr_held;
  logic [USE_W-1:0]      in_use_next;
  logic [USE_W-1:0]      peak_next;

  assign in_range = ({1'b0, block_index} < NB_LIMIT);

  // Find lowest free block
  always_comb begin
    free_idx = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!held[i]) free_idx = IDX_W'(i);
    end
  end
  assign any_free = ~&held;

  // Capture request and read the addressed count
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= opcode;
      idx_q      <= block_index;
      range_q    <= in_range;
      held_q     <= in_range && held[block_index];
      free_q     <= free_idx;
      any_free_q <= any_free;
      if (in_range) rd_q <= counts[block_index];
    end
  end

  assign cur_cnt = held_q ? rd_q : '0;

  // Decide result and state update
  always_comb begin
    res_status  = ST_OK;
    res_idx     = idx_q;
    res_cnt     = '0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;
    set_held    = 1'b0;
    clr_held    = 1'b0;
    in_use_next = in_use_total;
    peak_next   = peak_total;
    if (op_q == OP_ALLOC) begin
      if (any_free_q) begin
        res_idx     = free_q;
        res_cnt     = COUNT_ONE;
        wr_en       = 1'b1;
        wr_addr     = free_q;
        wr_data     = COUNT_ONE;
        set_held    = 1'b1;
        in_use_next = in_use_total + USE_ONE;
        if (in_use_next > peak_total) peak_next = in_use_next;
      end else begin
        res_status = ST_NO_FREE;
        res_idx    = '0;
      end
    end else if (!range_q) begin
      res_status = (op_q == OP_NOP) ? ST_OK : ST_RANGE;
    end else if (op_q == OP_NOP) begin
      res_cnt = cur_cnt;
    end else if (!held_q) begin
      res_status = ST_NOT_HELD;
    end else if (op_q == OP_RELEASE) begin
      wr_en   = 1'b1;
      wr_data = cur_cnt - COUNT_ONE;
      res_cnt = wr_data;
      if (wr_data == '0) begin
        clr_held = 1'b1;
        if (in_use_total != '0) in_use_next = in_use_total - USE_ONE;
      end
    end else begin
      if (cur_cnt == COUNT_MAX) begin
        res_status = ST_OVERFLOW;
        res_cnt    = cur_cnt;
      end else begin
        wr_en   = 1'b1;
        wr_data = cur_cnt + COUNT_ONE;
        res_cnt = wr_data;
      end
    end
  end

  // Write back the count
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) counts[wr_addr] <= wr_data;
  end

  // Update held bitmap and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      in_use_total <= '0;
      peak_total   <= '0;
    end else if (cmd.commit) begin
      if (set_held) held[wr_addr] <= 1'b1;
      if (clr_held) held[wr_addr] <= 1'b0;
      in_use_total <= in_use_next;
      peak_total   <= peak_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= res_status;
      granted_index   <= res_idx;
      ref_count_after <= res_cnt;
      blocks_in_use   <= in_use_next;
      peak_in_use     <= peak_next;
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

endmodule

// ===== hw/rtl/refcounted_block_pool_allocator_unit.sv =====
// Channel  Handshake            Payload
// in       in_valid/in_ready    opcode, block_index
// out      out_valid/out_ready  status, granted_index, ref_count_after,
//                               blocks_in_use, peak_in_use
//
// Each request is first captured, with the count memory read and the lowest free block
// latched; it then writes back and loads the result register.
// One request is in flight at a time; the count memory's read-modify-write sets this.
// Reset (rst, synchronous) clears the held bitmap and totals; no clearing pass.
// A full result register not taken stalls write-back; the next request waits.
module refcounted_block_pool_allocator_unit
  import rbpa_pkg::*;
#(
  parameter int NUM_BLOCKS = 64,
  parameter int COUNT_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  opcode_t                               opcode,
  input  logic [$clog2(NUM_BLOCKS)-1:0]         block_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output status_t                               status,
  output logic [$clog2(NUM_BLOCKS)-1:0]         granted_index,
  output logic [COUNT_BITS-1:0]                 ref_count_after,
  output logic [$clog2(NUM_BLOCKS + 1)-1:0]     blocks_in_use,
  output logic [$clog2(NUM_BLOCKS + 1)-1:0]     peak_in_use
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int USE_W = $clog2(NUM_BLOCKS + 1);

  rbpa_cmd_t  cmd;
  rbpa_stat_t stat;

  rbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .USE_W      (USE_W)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (opcode),
    .block_index     (block_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_index   (granted_index),
    .ref_count_after (ref_count_after),
    .blocks_in_use   (blocks_in_use),
    .peak_in_use     (peak_in_use)
  );

endmodule

// ===== tb/refcounted_block_pool_allocator_unit_tb.sv =====
module refcounted_block_pool_allocator_unit_tb
  import rbpa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 64;
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  // Two copies of the pool state: one steers the request generator, one checks results
  localparam int PLAN = 0;
  localparam int TRACK = 1;
  localparam int PHASE_ITEMS = 430;

  typedef struct packed {
    opcode_t     op;
    logic [5:0]  idx;
  } pool_req_t;

  typedef struct packed {
    status_t     st;
    logic [5:0]  idx;
    logic [7:0]  cnt;
    logic [6:0]  used;
    logic [6:0]  peak;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  opcode_t     opcode = OP_ALLOC;
  logic [5:0]  block_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_t     status;
  logic [5:0]  granted_index;
  logic [7:0]  ref_count_after;
  logic [6:0]  blocks_in_use;
  logic [6:0]  peak_in_use;

  logic        in_fire = 1'b0;

  bit [7:0]    held_count [2][NB];
  bit [6:0]    live_total [2];
  bit [6:0]    live_peak [2];

  pool_req_t    pool_reqs_pending [$];
  pool_result_t outcomes_due [$];
  int unsigned  issued = 0;
  int unsigned  errors = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;

  refcounted_block_pool_allocator_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .block_index     (block_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_index   (granted_index),
    .ref_count_after (ref_count_after),
    .blocks_in_use   (blocks_in_use),
    .peak_in_use     (peak_in_use)
  );

  // Apply one request to pool copy v and return the result it produces
  function automatic pool_result_t pool_apply(int v, opcode_t op, logic [5:0] idx);
    pool_result_t r;
    int           first_free;
    r = '{st: ST_OK, idx: idx, cnt: '0, used: '0, peak: '0};
    first_free = -1;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < NB; i++)
        if (first_free < 0 && held_count[v][i] == 0) first_free = i;
      if (first_free < 0) begin
        r.st = ST_NO_FREE;
        r.idx = '0;
      end else begin
        held_count[v][first_free] = 8'd1;
        live_total[v]++;
        if (live_total[v] > live_peak[v]) live_peak[v] = live_total[v];
        r.idx = 6'(first_free);
        r.cnt = 8'd1;
      end
    end else if (int'(idx) >= NB) begin
      r.st = (op == OP_NOP) ? ST_OK : ST_RANGE;
    end else if (op == OP_NOP) begin
      r.cnt = held_count[v][idx];
    end else if (held_count[v][idx] == 0) begin
      r.st = ST_NOT_HELD;
    end else if (op == OP_RELEASE) begin
      held_count[v][idx]--;
      if (held_count[v][idx] == 0 && live_total[v] > 0) live_total[v]--;
      r.cnt = held_count[v][idx];
    end else if (held_count[v][idx] >= COUNT_MAX) begin
      r.st = ST_OVERFLOW;
      r.cnt = held_count[v][idx];
    end else begin
      held_count[v][idx]++;
      r.cnt = held_count[v][idx];
    end
    r.used = live_total[v];
    r.peak = live_peak[v];
    return r;
  endfunction

  // Queue a request for the driver and advance the planning copy
  function automatic pool_result_t issue(opcode_t op, logic [5:0] idx);
    pool_result_t r;
    r = pool_apply(PLAN, op, idx);
    pool_reqs_pending.push_back('{op: op, idx: idx});
    issued++;
    return r;
  endfunction

  // Pick a random held block, or any block when none is held
  function automatic logic [5:0] pick_held();
    logic [5:0] held [$];
    for (int i = 0; i < NB; i++)
      if (held_count[PLAN][i] != 0) held.push_back(6'(i));
    if (held.size() == 0) return 6'($urandom_range(NB - 1));
    return held[$urandom_range(held.size() - 1)];
  endfunction

  task automatic flag_error(string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Build one phase of random request sequences
  task automatic gen_phase(int unsigned quota);
    int unsigned  start;
    int unsigned  kind;
    int unsigned  len;
    int unsigned  pick;
    logic [5:0]   b;
    pool_result_t r;
    start = issued;
    while (issued - start < quota) begin
      kind = $urandom_range(15);
      if (kind == 0) begin
        // pump the busiest block up to saturation, push past it, then back off a little
        b = '0;
        for (int i = 0; i < NB; i++)
          if (held_count[PLAN][i] > held_count[PLAN][b]) b = 6'(i);
        if (held_count[PLAN][b] == 0) begin
          r = issue(OP_ALLOC, '0);
          b = r.idx;
        end
        if (held_count[PLAN][b] != 0) begin
          while (held_count[PLAN][b] < COUNT_MAX) void'(issue(OP_ADD_REF, b));
          repeat ($urandom_range(1, 3)) void'(issue(OP_ADD_REF, b));
          repeat ($urandom_range(1, 4)) void'(issue(OP_RELEASE, b));
        end
      end else if (kind <= 3) begin
        // fill the pool, then ask for more than it holds
        while (live_total[PLAN] < NB) void'(issue(OP_ALLOC, 6'($urandom_range(NB - 1))));
        repeat ($urandom_range(1, 3)) void'(issue(OP_ALLOC, 6'($urandom_range(NB - 1))));
      end else if (kind <= 6) begin
        // drain held blocks
        len = $urandom_range(8, 64);
        repeat (len) void'(issue(OP_RELEASE, pick_held()));
      end else begin
        // mixed traffic with some noise
        len = $urandom_range(16, 48);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 35) void'(issue(OP_ALLOC, 6'($urandom_range(NB - 1))));
          else if (pick < 65) void'(issue(OP_RELEASE, pick_held()));
          else if (pick < 85) void'(issue(OP_ADD_REF, pick_held()));
          else void'(issue(opcode_t'($urandom_range(3)), 6'($urandom_range(NB - 1))));
        end
      end
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Drive requests at the falling edge; hold each until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pool_reqs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          opcode <= pool_reqs_pending[0].op;
          block_index <= pool_reqs_pending[0].idx;
          void'(pool_reqs_pending.pop_front());
        end else begin
          in_valid <= 1'b0;
          opcode <= opcode_t'($urandom_range(3));
          block_index <= 6'($urandom_range(NB - 1));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    pool_result_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (outcomes_due.size() == 0) begin
          flag_error("result with no request outstanding");
        end else begin
          want = outcomes_due.pop_front();
          if (status !== want.st)
            flag_error($sformatf("status got %0d want %0d", status, want.st));
          if (granted_index !== want.idx)
            flag_error($sformatf("granted_index got %0d want %0d", granted_index, want.idx));
          if (ref_count_after !== want.cnt)
            flag_error($sformatf("ref_count_after got %0d want %0d", ref_count_after,
                                 want.cnt));
          if (blocks_in_use !== want.used)
            flag_error($sformatf("blocks_in_use got %0d want %0d", blocks_in_use, want.used));
          if (peak_in_use !== want.peak)
            flag_error($sformatf("peak_in_use got %0d want %0d", peak_in_use, want.peak));
        end
      end
      if (in_valid && in_ready)
        outcomes_due.push_back(pool_apply(TRACK, opcode, block_index));
    end
  end

  initial begin : stimulus
    int unsigned sender_idle [4];
    int unsigned receiver_stall [4];
    sender_idle = '{0, 48, 0, 37};
    receiver_stall = '{0, 0, 48, 37};

    // directed requests: empty pool, reuse of the lowest block, not-held cases
    void'(issue(OP_NOP, 6'd0));
    void'(issue(OP_NOP, 6'd63));
    void'(issue(OP_RELEASE, 6'd0));
    void'(issue(OP_ADD_REF, 6'd63));
    void'(issue(OP_ALLOC, 6'd63));
    void'(issue(OP_ALLOC, 6'd0));
    void'(issue(OP_ALLOC, 6'd42));
    void'(issue(OP_ADD_REF, 6'd1));
    void'(issue(OP_ADD_REF, 6'd1));
    void'(issue(OP_NOP, 6'd1));
    void'(issue(OP_RELEASE, 6'd0));
    void'(issue(OP_ALLOC, 6'd21));
    void'(issue(OP_RELEASE, 6'd2));
    void'(issue(OP_RELEASE, 6'd2));
    void'(issue(OP_NOP, 6'd42));
    void'(issue(OP_NOP, 6'd21));
    void'(issue(OP_ADD_REF, 6'd42));
    void'(issue(OP_RELEASE, 6'd21));
    void'(issue(OP_RELEASE, 6'd1));
    void'(issue(OP_RELEASE, 6'd1));
    void'(issue(OP_RELEASE, 6'd1));
    void'(issue(OP_ALLOC, 6'd0));

    // random phases under different idle and stall rates
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sender_idle[p];
      stall_pct = receiver_stall[p];
      gen_phase(PHASE_ITEMS);
      while (pool_reqs_pending.size() != 0) @(posedge clk);
    end

    // drain outstanding results, then let the pipeline settle
    while (in_valid || outcomes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
